FILE: rtl/fmtk_pkg.sv
// fmtk_pkg: shared types, constants and register indexes for the FM tuning-knob controller.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package fmtk_pkg;

    // Default width of a knob sample
    localparam int SAMPLE_BITS_DEF = 10;

    // Frequency plan, 10 kHz units
    localparam int TUNE_SPAN_LOG = 11;     // knob full scale spans 2048 units
    localparam int BAND_LOW      = 8800;
    localparam int BAND_MID      = 9800;
    localparam int BAND_HIGH     = 10800;
    localparam int CH_HALF       = 10;     // half of the 200 kHz channel grid

    // rf/20 as (rf>>2)*RECIP_5 >> RECIP_SHIFT, exact for 16-bit rf
    localparam int RECIP_5       = 52429;
    localparam int RECIP_SHIFT   = 18;
    localparam int Q_BITS        = 12;     // 65535/20 < 4096

    // Field widths
    localparam int FREQ_BITS     = 16;
    localparam int LO_BITS       = 14;
    localparam int OFFSET_BITS   = 11;
    localparam int STR_BITS      = 10;
    localparam int BARS_BITS     = 3;
    localparam int BARS_MAX      = 4;
    localparam int CFG_DATA_BITS = 16;

    // Register reset values
    localparam logic [FREQ_BITS-1:0]   TUNE_BASE_RST = 16'd8776;
    localparam logic [OFFSET_BITS-1:0] IF_OFFSET_RST = 11'd1070;
    localparam logic [STR_BITS-1:0]    STR_LOW_RST   = 10'd400;
    localparam logic [STR_BITS-1:0]    STR_HIGH_RST  = 10'd660;

    typedef enum logic [1:0] {
        CFG_TUNE_BASE = 2'd0,
        CFG_IF_OFFSET = 2'd1,
        CFG_STR_LOW   = 2'd2,
        CFG_STR_HIGH  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [FREQ_BITS-1:0]   tune_base;
        logic [OFFSET_BITS-1:0] if_offset;
        logic [STR_BITS-1:0]    strength_low;
        logic [STR_BITS-1:0]    strength_high;
    } t_cfg;

    // Load strobes of the three pipeline registers
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

`default_nettype wire

FILE: rtl/fmtk_ifs.sv
// fmtk_ifs: valid/ready channel interfaces of the FM tuning-knob controller
// (sample input, result output, register write). Depends on fmtk_pkg.
`default_nettype none

interface fmtk_in_if
    import fmtk_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] tuning_sample;
    logic [STR_BITS-1:0]    strength_sample;

    modport source (output valid, tuning_sample, strength_sample, input ready);
    modport sink   (input valid, tuning_sample, strength_sample, output ready);
endinterface

interface fmtk_out_if
    import fmtk_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [FREQ_BITS-1:0] rf_freq;
    logic [FREQ_BITS-1:0] channel_freq;
    logic [LO_BITS-1:0]   lo_freq;
    logic                 retune;
    logic [BARS_BITS-1:0] signal_bars;

    modport source (output valid, rf_freq, channel_freq, lo_freq, retune, signal_bars,
                    input ready);
    modport sink   (input valid, rf_freq, channel_freq, lo_freq, retune, signal_bars,
                    output ready);
endinterface

interface fmtk_cfg_if
    import fmtk_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_cfg_idx                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fmtk_cfg_regs.sv
// fmtk_cfg_regs: configuration register file, written one register per transfer.
// Depends on fmtk_pkg.
`default_nettype none

module fmtk_cfg_regs
    import fmtk_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_valid,
    input  wire t_cfg_idx                 i_wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_wr_data,
    output logic                          o_wr_ready,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (i_wr_index)
                CFG_TUNE_BASE: n_cfg.tune_base     = i_wr_data;
                CFG_IF_OFFSET: n_cfg.if_offset     = i_wr_data[OFFSET_BITS-1:0];
                CFG_STR_LOW:   n_cfg.strength_low  = i_wr_data[STR_BITS-1:0];
                CFG_STR_HIGH:  n_cfg.strength_high = i_wr_data[STR_BITS-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tune_base     <= TUNE_BASE_RST;
            r_cfg.if_offset     <= IF_OFFSET_RST;
            r_cfg.strength_low  <= STR_LOW_RST;
            r_cfg.strength_high <= STR_HIGH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmtk_tune.sv
// fmtk_tune: knob smoothing, RF frequency, channel snap and LO hold, three register stages.
// Depends on fmtk_pkg; stage loads come from the top-level pipeline control.
`default_nettype none

module fmtk_tune
    import fmtk_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_pipe_ctl              i_ctl,
    input  wire t_cfg                   i_cfg,
    input  wire logic [SAMPLE_BITS-1:0] i_tuning_sample,
    output logic [FREQ_BITS-1:0]        o_rf_freq,
    output logic [FREQ_BITS-1:0]        o_channel_freq,
    output logic [LO_BITS-1:0]          o_lo_freq,
    output logic                        o_retune
);

    localparam int SCALE_BITS = TUNE_SPAN_LOG;
    localparam int WIDE_BITS  = SAMPLE_BITS + SCALE_BITS;
    localparam int PROD_BITS  = 2 * FREQ_BITS - 2;

    // Stage 1: smoothed knob value, also the running-average state
    logic [SAMPLE_BITS-1:0] r_smooth;
    logic [SAMPLE_BITS-1:0] n_smooth;
    logic [SAMPLE_BITS+1:0] smooth_sum;

    // Stage 2: RF frequency and rf/20
    logic [FREQ_BITS-1:0]   r2_rf;
    logic [Q_BITS-1:0]      r2_q;
    logic [FREQ_BITS-1:0]   n_rf;
    logic [Q_BITS-1:0]      n_q;
    logic [WIDE_BITS-1:0]   scale_wide;
    logic [PROD_BITS-1:0]   prod;

    // Stage 3: result registers; r_ch doubles as the last channel
    logic [FREQ_BITS-1:0]   r_rf;
    logic [FREQ_BITS-1:0]   r_ch;
    logic [LO_BITS-1:0]     r_held_lo;
    logic                   r_retune;
    logic [FREQ_BITS-1:0]   n_ch;
    logic [FREQ_BITS-1:0]   lo_wide;
    logic                   n_retune;

    // (3*s + x) / 4
    assign smooth_sum = {2'b00, r_smooth} + {1'b0, r_smooth, 1'b0}
                      + {2'b00, i_tuning_sample};
    assign n_smooth   = smooth_sum[SAMPLE_BITS+1:2];

    // 2048*s >> SAMPLE_BITS, always below 2048
    assign scale_wide = {r_smooth, {SCALE_BITS{1'b0}}} >> SAMPLE_BITS;
    assign n_rf       = i_cfg.tune_base + FREQ_BITS'(scale_wide[SCALE_BITS-1:0]);
    assign prod       = PROD_BITS'(n_rf[FREQ_BITS-1:2]) * PROD_BITS'(RECIP_5);
    assign n_q        = prod[RECIP_SHIFT +: Q_BITS];

    assign n_ch     = {r2_q, 4'b0000} + {2'b00, r2_q, 2'b00} + FREQ_BITS'(CH_HALF);
    assign n_retune = (n_ch != r_ch);

    always_comb begin
        if (n_ch >= FREQ_BITS'(BAND_LOW) && n_ch < FREQ_BITS'(BAND_MID)) begin
            lo_wide = n_ch - FREQ_BITS'(i_cfg.if_offset);
        end else if (n_ch >= FREQ_BITS'(BAND_MID) && n_ch <= FREQ_BITS'(BAND_HIGH)) begin
            lo_wide = n_ch + FREQ_BITS'(i_cfg.if_offset);
        end else begin
            lo_wide = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth  <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
            r_ch      <= '0;
            r_held_lo <= '0;
        end else begin
            if (i_ctl.ld1) begin
                r_smooth <= n_smooth;
            end
            if (i_ctl.ld3) begin
                r_ch <= n_ch;
                if (n_retune) begin
                    r_held_lo <= lo_wide[LO_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r2_rf <= n_rf;
            r2_q  <= n_q;
        end
        if (i_ctl.ld3) begin
            r_rf     <= r2_rf;
            r_retune <= n_retune;
        end
    end

    assign o_rf_freq      = r_rf;
    assign o_channel_freq = r_ch;
    assign o_lo_freq      = r_held_lo;
    assign o_retune       = r_retune;

    // Retune flag reports exactly a change of channel
    a_retune_matches_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ld3 |=> (r_retune == ($past(r_ch) != r_ch)))
        else $error("retune flag disagrees with channel change");

    // A held LO is nonzero exactly while the channel sits in the band
    a_lo_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_lo != '0) ==
        (r_ch >= FREQ_BITS'(BAND_LOW) && r_ch <= FREQ_BITS'(BAND_HIGH)))
        else $error("held LO inconsistent with channel band");

endmodule

`default_nettype wire

FILE: rtl/fmtk_bars.sv
// fmtk_bars: lock-detect clamp and signal bar count by threshold compare, three stages.
// Depends on fmtk_pkg; stage loads come from the top-level pipeline control.
`default_nettype none

module fmtk_bars
    import fmtk_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_pipe_ctl           i_ctl,
    input  wire t_cfg                i_cfg,
    input  wire logic [STR_BITS-1:0] i_strength_sample,
    output logic [BARS_BITS-1:0]     o_signal_bars
);

    logic [STR_BITS-1:0]   r1_strength;
    logic [BARS_BITS-1:0]  r2_bars;
    logic [BARS_BITS-1:0]  r3_bars;
    logic [BARS_BITS-1:0]  n_bars;

    logic [STR_BITS-1:0]   s_clamp;
    logic [STR_BITS-1:0]   s_rel;
    logic [STR_BITS+2:0]   dist5;      // 5*(s-low)
    logic [STR_BITS-1:0]   span;
    logic [STR_BITS+2:0]   thr1;
    logic [STR_BITS+2:0]   thr2;
    logic [STR_BITS+2:0]   thr3;
    logic [STR_BITS+2:0]   thr4;

    always_comb begin
        if (i_cfg.strength_high <= i_cfg.strength_low) begin
            s_clamp = i_cfg.strength_low;
        end else if (r1_strength < i_cfg.strength_low) begin
            s_clamp = i_cfg.strength_low;
        end else if (r1_strength > i_cfg.strength_high) begin
            s_clamp = i_cfg.strength_high;
        end else begin
            s_clamp = r1_strength;
        end
    end

    assign s_rel = s_clamp - i_cfg.strength_low;
    assign dist5 = {1'b0, s_rel, 2'b00} + {3'b000, s_rel};
    assign span  = i_cfg.strength_high - i_cfg.strength_low;
    assign thr1  = {3'b000, span};
    assign thr2  = {2'b00, span, 1'b0};
    assign thr3  = {2'b00, span, 1'b0} + {3'b000, span};
    assign thr4  = {1'b0, span, 2'b00};

    // Inverted limits leave dist5 at zero; a zero span is caught here too
    always_comb begin
        if (i_cfg.strength_high <= i_cfg.strength_low) begin
            n_bars = '0;
        end else if (dist5 >= thr4) begin
            n_bars = BARS_BITS'(4);
        end else if (dist5 >= thr3) begin
            n_bars = BARS_BITS'(3);
        end else if (dist5 >= thr2) begin
            n_bars = BARS_BITS'(2);
        end else if (dist5 >= thr1) begin
            n_bars = BARS_BITS'(1);
        end else begin
            n_bars = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r1_strength <= i_strength_sample;
        end
        if (i_ctl.ld2) begin
            r2_bars <= n_bars;
        end
        if (i_ctl.ld3) begin
            r3_bars <= r2_bars;
        end
    end

    assign o_signal_bars = r3_bars;

endmodule

`default_nettype wire

FILE: rtl/fm_tuning_knob_controller_top.sv
// FM tuning-knob controller, top level: one tuning-knob sample and one lock-detect
// sample per input transfer, one result transfer per item, in order. The block takes
// one item every clock cycle sustained while the output is ready. Each item passes three
// register stages (input register holding the smoothed knob value, RF/channel-divide
// register, result register), and its result is presented from the result register.
// The smoothing add and the last-channel compare are the only datapath loops, which is
// why one item per cycle holds.
// Each stage advances whenever the stage after it is empty or moving, so bubbles are
// squeezed out and input is still taken while a finished result waits at the output.
// Registers (tune_base, if_offset, strength_low, strength_high) are written through the
// config channel, which is always ready; write them only while no item is in flight.
// No memories, no clearing pass: the block is ready on the first cycle after reset.
// Depends on fmtk_pkg, fmtk_ifs, fmtk_cfg_regs, fmtk_tune and fmtk_bars.
`default_nettype none

module fm_tuning_knob_controller_top
    import fmtk_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fmtk_in_if.sink     i_in,
    fmtk_out_if.source  o_out,
    fmtk_cfg_if.sink    i_cfg
);

    // Stage valid bits
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    logic      n_v1;
    logic      n_v2;
    logic      n_v3;

    // A stage may load when it is empty or its content moves on this cycle
    logic      rdy1;
    logic      rdy2;
    logic      rdy3;

    t_pipe_ctl ctl;
    t_cfg      cfg;

    assign rdy3 = !r_v3 || o_out.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign ctl.ld1 = i_in.valid && rdy1;
    assign ctl.ld2 = r_v1 && rdy2;
    assign ctl.ld3 = r_v2 && rdy3;

    assign i_in.ready  = rdy1;
    assign o_out.valid = r_v3;

    always_comb begin
        n_v1 = ctl.ld1 ? 1'b1 : (ctl.ld2 ? 1'b0 : r_v1);
        n_v2 = ctl.ld2 ? 1'b1 : (ctl.ld3 ? 1'b0 : r_v2);
        n_v3 = ctl.ld3 ? 1'b1 : (o_out.ready ? 1'b0 : r_v3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // Configuration registers
    fmtk_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    // Frequency path: smoothing, RF, channel snap, LO hold
    fmtk_tune #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tune (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_cfg           (cfg),
        .i_tuning_sample (i_in.tuning_sample),
        .o_rf_freq       (o_out.rf_freq),
        .o_channel_freq  (o_out.channel_freq),
        .o_lo_freq       (o_out.lo_freq),
        .o_retune        (o_out.retune)
    );

    // Strength path: clamp and bar count
    fmtk_bars u_bars (
        .i_clk             (i_clk),
        .i_ctl             (ctl),
        .i_cfg             (cfg),
        .i_strength_sample (i_in.strength_sample),
        .o_signal_bars     (o_out.signal_bars)
    );

    // Full pipeline behind a stalled output takes no new transfer
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted into a full pipeline");

    // Bar count stays within its saturated range
    a_bars_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.signal_bars <= BARS_BITS'(BARS_MAX)))
        else $error("signal bar count above saturation");

endmodule

`default_nettype wire
